FILE: sv/soa_pkg.sv
// Shared types and constants for the slab object allocator.
package soa_pkg;
  localparam int NUM_SLABS_DEF  = 16;
  localparam int MAX_OBJS_DEF   = 128;
  localparam int SLAB_BYTES_DEF = 4096;
  localparam logic [11:0] FREE_MAX = 12'd4095;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [0:0] CFG_OBJ_BYTES = 1'b0;
  localparam logic [0:0] CFG_OBJS_PER  = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [3:0]  slab_id;
    logic [11:0] obj_offset;
  } req_t;

  typedef struct packed {
    logic        status;
    logic [3:0]  out_slab;
    logic [6:0]  out_index;
    logic [11:0] out_offset;
    logic        slab_grown;
    logic        slab_released;
    logic [11:0] free_total;
  } rsp_t;
endpackage

FILE: sv/slab_object_allocator_top.sv
// Slab object allocator top level: sequencer, slab tables and link memory.
//
// channel | signals                          | handshake
// request | start, busy, req                 | taken when start && !busy
// result  | done, rsp                        | one-cycle strobe, no stall
// config  | cfg_valid, cfg_ready, cfg_index, | taken when valid && ready
//         |   cfg_data                       |
//
// An alloc from a live slab passes through find, read and pop; growing a slab
// first writes its link chain, one entry per object (effective objs_per_slab).
// A failed alloc ends after the find step. A free loads the offset, runs the
// bit-serial divide by object size, then hands off the quotient and pushes.
// Reset is synchronous; link memory contents are undefined until a slab grows.
// The result strobe cannot be held off.
module slab_object_allocator_top #(
  parameter int NUM_SLABS  = soa_pkg::NUM_SLABS_DEF,
  parameter int MAX_OBJS   = soa_pkg::MAX_OBJS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  soa_pkg::req_t req,
  output logic          done,
  output soa_pkg::rsp_t rsp,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_index,
  input  logic [12:0]   cfg_data
);
  localparam int SW = (NUM_SLABS > 1) ? $clog2(NUM_SLABS) : 1;
  localparam int IW = $clog2(MAX_OBJS);
  localparam int LW = IW + 1;
  localparam int AW = $clog2(NUM_SLABS * MAX_OBJS);
  localparam logic [LW-1:0] LEND = LW'(MAX_OBJS);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FIND  = 7'b0000010,
    S_GROW  = 7'b0000100,
    S_RD    = 7'b0001000,
    S_POP   = 7'b0010000,
    S_DIV   = 7'b0100000,
    S_PUSH  = 7'b1000000
  } state_t;

  state_t state;
  logic [12:0] obj_bytes;
  logic [7:0]  objs_per_slab;
  logic [LW-1:0] free_head [NUM_SLABS];
  logic [7:0]    inuse     [NUM_SLABS];
  logic [NUM_SLABS-1:0] live;
  logic [11:0] free_sum;
  soa_pkg::req_t cur;
  logic [SW-1:0] slab;
  logic [LW-1:0] idx;
  logic          grown;
  logic [LW-1:0] gi;

  logic [12:0] size_eff;
  logic [LW-1:0] n_eff;
  assign size_eff = (obj_bytes == 13'd0) ? 13'd1 : obj_bytes;
  always_comb begin
    if (objs_per_slab == 8'd0) n_eff = LW'(1);
    else if ({1'b0, objs_per_slab} > 9'(MAX_OBJS)) n_eff = LW'(MAX_OBJS);
    else n_eff = LW'(objs_per_slab);
  end

  // link memory
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [LW-1:0] wdata, rdata;
  soa_ram #(.WIDTH(LW), .DEPTH(NUM_SLABS * MAX_OBJS)) u_link (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // divider loads the offset at the accepting edge
  logic        div_go, div_done;
  logic [11:0] quo;
  soa_div u_div (
    .clk(clk), .rst(rst), .go(div_go), .dividend(req.obj_offset), .divisor(size_eff),
    .done(div_done), .quotient(quo)
  );

  // slab search
  logic          have_free, have_unused;
  logic [SW-1:0] free_sel, unused_sel;
  always_comb begin
    have_free = 1'b0; have_unused = 1'b0;
    free_sel = '0; unused_sel = '0;
    for (int s = NUM_SLABS - 1; s >= 0; s--) begin
      if (live[s] && free_head[s] != LEND) begin
        have_free = 1'b1; free_sel = SW'(s);
      end
      if (!live[s]) begin
        have_unused = 1'b1; unused_sel = SW'(s);
      end
    end
  end

  function automatic logic [11:0] fadd(logic [11:0] a, logic [LW-1:0] b);
    logic [12:0] t;
    t = {1'b0, a} + 13'(b);
    return t[12] ? soa_pkg::FREE_MAX : t[11:0];
  endfunction
  function automatic logic [11:0] fsub(logic [11:0] a, logic [LW-1:0] b);
    return (a > 12'(b)) ? a - 12'(b) : 12'd0;
  endfunction

  logic [24:0] prod;
  assign prod = 25'(idx) * 25'(size_eff);

  logic div_hit;
  assign div_hit = (quo < 12'(n_eff));

  assign busy      = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign div_go    = (state == S_IDLE) && start && req.req_type == soa_pkg::REQ_FREE;

  always_comb begin
    we = 1'b0; waddr = '0; wdata = '0;
    raddr = AW'({slab, idx[IW-1:0]});
    if (state == S_GROW) begin
      we = 1'b1;
      waddr = AW'({slab, gi[IW-1:0]});
      wdata = (gi + LW'(1) == n_eff) ? LEND : gi + LW'(1);
    end else if (state == S_PUSH && live[slab] && div_hit) begin
      we = 1'b1;
      waddr = AW'({slab, quo[IW-1:0]});
      wdata = free_head[slab];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      obj_bytes <= 13'd32;
      objs_per_slab <= 8'd120;
      live <= '0;
      free_sum <= '0;
      done <= 1'b0;
      for (int s = 0; s < NUM_SLABS; s++) begin
        free_head[s] <= LEND;
        inuse[s] <= '0;
      end
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == soa_pkg::CFG_OBJ_BYTES) obj_bytes <= cfg_data;
        else objs_per_slab <= cfg_data[7:0];
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            cur <= req;
            grown <= 1'b0;
            state <= (req.req_type == soa_pkg::REQ_FREE) ? S_DIV : S_FIND;
          end
        end
        S_FIND: begin
          gi <= '0;
          if (have_free) begin
            slab <= free_sel;
            idx  <= free_head[free_sel];
            state <= S_RD;
          end else if (have_unused) begin
            slab <= unused_sel;
            idx  <= '0;
            grown <= 1'b1;
            state <= S_GROW;
          end else begin
            rsp <= '{status: 1'b1, out_slab: '0, out_index: '0, out_offset: '0,
                     slab_grown: 1'b0, slab_released: 1'b0, free_total: free_sum};
            done <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_GROW: begin
          gi <= gi + LW'(1);
          if (gi + LW'(1) == n_eff) begin
            free_head[slab] <= '0;
            inuse[slab] <= '0;
            live[slab] <= 1'b1;
            free_sum <= fadd(free_sum, n_eff);
            state <= S_RD;
          end
        end
        S_RD: begin
          // read data for entry idx lands next cycle
          if (idx[LW-1]) idx <= '0;
          state <= S_POP;
        end
        S_POP: begin
          free_head[slab] <= rdata;
          inuse[slab] <= inuse[slab] + 8'd1;
          free_sum <= fsub(free_sum, LW'(1));
          rsp <= '{status: 1'b0, out_slab: 4'(slab), out_index: 7'(idx),
                   out_offset: prod[11:0], slab_grown: grown, slab_released: 1'b0,
                   free_total: fsub(free_sum, LW'(1))};
          done <= 1'b1;
          state <= S_IDLE;
        end
        S_DIV: begin
          slab <= SW'(cur.slab_id);
          if (div_done) begin
            idx <= LW'(quo);
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          if ({1'b0, cur.slab_id} < 5'(NUM_SLABS) && live[slab] && div_hit) begin
            logic [7:0]  nu;
            logic [11:0] fa;
            nu = (inuse[slab] != 8'd0) ? inuse[slab] - 8'd1 : 8'd0;
            fa = fadd(free_sum, LW'(1));
            inuse[slab] <= nu;
            if (nu == 8'd0) begin
              live[slab] <= 1'b0;
              free_head[slab] <= LEND;
              free_sum <= fsub(fa, n_eff);
            end else begin
              free_head[slab] <= LW'(quo);
              free_sum <= fa;
            end
            rsp <= '{status: 1'b0, out_slab: cur.slab_id, out_index: 7'(quo),
                     out_offset: prod[11:0], slab_grown: 1'b0,
                     slab_released: (nu == 8'd0),
                     free_total: (nu == 8'd0) ? fsub(fa, n_eff) : fa};
          end else begin
            rsp <= '{status: 1'b0, out_slab: cur.slab_id, out_index: '0, out_offset: '0,
                     slab_grown: 1'b0, slab_released: 1'b0, free_total: free_sum};
          end
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_IDLE) else $error("result strobe outside idle");
  a_fail_nochg: assert property (@(posedge clk) disable iff (rst)
    done && rsp.status |-> !rsp.slab_grown && !rsp.slab_released)
    else $error("failed alloc carries flags");
  a_grow_write: assert property (@(posedge clk) disable iff (rst)
    state == S_GROW |-> we) else $error("grow without link write");
endmodule

FILE: sv/soa_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
module soa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: sv/soa_div.sv
// Restoring divider: offset by object size, one quotient bit per cycle.
module soa_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [11:0] dividend,
  input  logic [12:0] divisor,
  output logic        done,
  output logic [11:0] quotient
);
  logic [11:0] rem;
  logic [11:0] q;
  logic [3:0]  cnt;
  logic        run;

  assign quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= 4'd0;
        rem <= '0;
        q   <= dividend;
      end else if (run) begin
        // shift in next dividend bit, subtract if it fits
        if ({1'b0, rem, q[11]} >= {1'b0, divisor}) begin
          rem <= 12'({rem, q[11]} - divisor);
          q   <= {q[10:0], 1'b1};
        end else begin
          rem <= {rem[10:0], q[11]};
          q   <= {q[10:0], 1'b0};
        end
        cnt <= cnt + 4'd1;
        if (cnt == 4'd11) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
